### src/lrq_pkg.sv
// Shared types and constants for the Lamport request queue block.
// Used by lrq_ctrl, lrq_dpath and lamport_request_queue_core; depends on nothing.
`default_nettype none

package lrq_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int STAMP_W   = 31;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_RECORD = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_PROCS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EVAL  = 3'b010,
        ST_APPLY = 3'b100
    } lrq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic apply;
    } lrq_cmd_t;

endpackage

`default_nettype wire

### src/lrq_ctrl.sv
// Controller state machine of the Lamport request queue: sequences load,
// compare and update of one transaction. Depends on lrq_pkg.
`default_nettype none

module lrq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output lrq_pkg::lrq_cmd_t      cmd
);
    import lrq_pkg::*;

    lrq_state_t state_reg;
    lrq_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:  state_next = ST_APPLY;
            ST_APPLY: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cmd.load  = (state_reg == ST_IDLE) && start;
    assign cmd.eval  = (state_reg == ST_EVAL);
    assign cmd.apply = (state_reg == ST_APPLY);

endmodule

`default_nettype wire

### src/lrq_dpath.sv
// Datapath of the Lamport request queue: configuration registers, the sorted
// cell chain, the latest-stamp vector and the result registers. Depends on lrq_pkg.
`default_nettype none

module lrq_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lrq_pkg::lrq_cmd_t             cmd,
    input  wire logic [1:0]                    mode,
    input  wire logic [lrq_pkg::STAMP_W-1:0]   stamp,
    input  wire logic [lrq_pkg::IDX_W-1:0]     proc_id,
    input  wire logic                          cfg_write,
    input  wire logic [lrq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lrq_pkg::CFG_W-1:0]     cfg_data,
    output logic                               done,
    output logic                               granted,
    output logic                               found,
    output logic [lrq_pkg::IDX_W-1:0]          position,
    output logic [lrq_pkg::CNT_W-1:0]          entry_total,
    output logic                               rejected
);
    import lrq_pkg::*;

    // Latched transaction.
    mode_t                mode_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    logic [IDX_W-1:0]     pid_reg;

    // Configuration.
    logic [CNT_W-1:0]     num_procs_reg;
    logic [IDX_W-1:0]     own_id_reg;
    logic [CNT_W-1:0]     slots_reg;

    // Sorted queue cells and the latest stamp of each process.
    logic [STAMP_W-1:0]   ent_stamp_reg [MAX_PROCS];
    logic [IDX_W-1:0]     ent_id_reg    [MAX_PROCS];
    logic [STAMP_W-1:0]   ent_stamp_next[MAX_PROCS];
    logic [IDX_W-1:0]     ent_id_next   [MAX_PROCS];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [STAMP_W-1:0]   latest_reg    [MAX_PROCS];

    // Per-cell compare results, registered between the compare and update steps.
    logic [MAX_PROCS-1:0] gt_reg;
    logic [MAX_PROCS-1:0] gt_next;
    logic [MAX_PROCS-1:0] match_reg;
    logic [MAX_PROCS-1:0] match_next;
    logic [MAX_PROCS-1:0] tsok_reg;
    logic [MAX_PROCS-1:0] tsok_next;

    logic [MAX_PROCS-1:0] valid;
    logic [MAX_PROCS-1:0] keep;
    logic [MAX_PROCS-1:0] keep_prev;
    logic [MAX_PROCS-1:0] seen;
    logic [STAMP_W-1:0]   up_stamp[MAX_PROCS];
    logic [IDX_W-1:0]     up_id   [MAX_PROCS];
    logic [STAMP_W-1:0]   dn_stamp[MAX_PROCS];
    logic [IDX_W-1:0]     dn_id   [MAX_PROCS];
    logic [IDX_W-1:0]     target_id;
    logic [IDX_W-1:0]     first_pos;
    logic                 any_match;
    logic                 full;

    logic                 done_reg;
    logic                 granted_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     position_reg;
    logic [CNT_W-1:0]     entry_total_reg;
    logic                 rejected_reg;

    assign target_id = (mode_reg == MODE_QUERY) ? own_id_reg : pid_reg;
    assign full      = (count_reg >= CNT_W'(MAX_PROCS));
    assign any_match = |match_reg;

    // Neighbor taps of each cell: the one above feeds an insert shift, the one
    // below feeds a remove shift.
    for (genvar k = 0; k < MAX_PROCS; k++)
    begin : g_cell
        assign valid[k] = (CNT_W'(k) < count_reg);
        assign keep[k]  = valid[k] && !gt_reg[k];
        if (k == 0)
        begin : g_head
            assign up_stamp[k]  = stamp_reg;
            assign up_id[k]     = pid_reg;
            assign keep_prev[k] = 1'b1;
        end
        else
        begin : g_body
            assign up_stamp[k]  = ent_stamp_reg[k-1];
            assign up_id[k]     = ent_id_reg[k-1];
            assign keep_prev[k] = keep[k-1];
        end
        if (k == MAX_PROCS - 1)
        begin : g_tail
            assign dn_stamp[k] = ent_stamp_reg[k];
            assign dn_id[k]    = ent_id_reg[k];
        end
        else
        begin : g_inner
            assign dn_stamp[k] = ent_stamp_reg[k+1];
            assign dn_id[k]    = ent_id_reg[k+1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_PROCS; k++)
        begin
            gt_next[k] = valid[k] && ((ent_stamp_reg[k] > stamp_reg) ||
                         ((ent_stamp_reg[k] == stamp_reg) && (ent_id_reg[k] > pid_reg)));
            match_next[k] = valid[k] && (ent_id_reg[k] == target_id);
            tsok_next[k]  = (CNT_W'(k) >= num_procs_reg) ||
                            (IDX_W'(k) == own_id_reg) ||
                            (latest_reg[k] > stamp_reg);
        end
    end

    // First matching cell: every cell from there on pulls from below on remove.
    always_comb
    begin
        seen[0] = match_reg[0];
        for (int k = 1; k < MAX_PROCS; k++)
        begin
            seen[k] = seen[k-1] | match_reg[k];
        end
        first_pos = '0;
        for (int k = MAX_PROCS - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                first_pos = IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int k = 0; k < MAX_PROCS; k++)
        begin
            ent_stamp_next[k] = ent_stamp_reg[k];
            ent_id_next[k]    = ent_id_reg[k];
        end
        unique case (mode_reg)
            MODE_INSERT:
            begin
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                    for (int k = 0; k < MAX_PROCS; k++)
                    begin
                        if (!keep[k])
                        begin
                            ent_stamp_next[k] = keep_prev[k] ? stamp_reg : up_stamp[k];
                            ent_id_next[k]    = keep_prev[k] ? pid_reg : up_id[k];
                        end
                    end
                end
            end
            MODE_REMOVE:
            begin
                if (any_match)
                begin
                    count_next = count_reg - CNT_W'(1);
                    for (int k = 0; k < MAX_PROCS; k++)
                    begin
                        if (seen[k])
                        begin
                            ent_stamp_next[k] = dn_stamp[k];
                            ent_id_next[k]    = dn_id[k];
                        end
                    end
                end
            end
            MODE_RECORD, MODE_QUERY:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_procs_reg <= CNT_W'(MAX_PROCS);
            own_id_reg    <= '0;
            slots_reg     <= CNT_W'(1);
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_NUM_PROCS)
            begin
                num_procs_reg <= cfg_data[CNT_W-1:0];
            end
            if (cfg_index == REG_OWN_ID)
            begin
                own_id_reg <= cfg_data[IDX_W-1:0];
            end
            if (cfg_index == REG_SLOTS)
            begin
                slots_reg <= cfg_data[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode_t'(mode);
            stamp_reg <= stamp;
            pid_reg   <= proc_id;
        end
        if (cmd.eval)
        begin
            gt_reg    <= gt_next;
            match_reg <= match_next;
            tsok_reg  <= tsok_next;
        end
        if (cmd.apply)
        begin
            for (int k = 0; k < MAX_PROCS; k++)
            begin
                ent_stamp_reg[k] <= ent_stamp_next[k];
                ent_id_reg[k]    <= ent_id_next[k];
            end
            granted_reg     <= (mode_reg == MODE_QUERY) && any_match &&
                               ({1'b0, first_pos} < slots_reg) && (&tsok_reg);
            found_reg       <= ((mode_reg == MODE_QUERY) || (mode_reg == MODE_REMOVE)) &&
                               any_match;
            position_reg    <= ((mode_reg == MODE_QUERY) && any_match) ? first_pos : '0;
            entry_total_reg <= count_next;
            rejected_reg    <= (mode_reg == MODE_INSERT) && full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            for (int k = 0; k < MAX_PROCS; k++)
            begin
                latest_reg[k] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.apply;
            if (cmd.apply)
            begin
                count_reg <= count_next;
                if (mode_reg == MODE_RECORD)
                begin
                    latest_reg[pid_reg] <= stamp_reg;
                end
            end
        end
    end

    assign done        = done_reg;
    assign granted     = granted_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_total = entry_total_reg;
    assign rejected    = rejected_reg;

endmodule

`default_nettype wire

### src/lamport_request_queue_core.sv
// Lamport mutual-exclusion request queue: top level joining controller and datapath.
// Depends on lrq_pkg, lrq_ctrl and lrq_dpath.
//
// A transaction is taken when start is high while busy is low. Every transaction
// gives exactly one result, shown on the result ports for one cycle with done high.
// The edge that takes it latches the request. The block then registers its compare
// against all sixteen queue cells and stamp registers, done in parallel, and after
// that updates the queue and the result registers. busy stays high over the compare
// and update steps, so a new transaction can be taken only once the last is through,
// at the edge that ends the cycle in which done is shown. The receiver cannot hold
// off a result. Configuration writes take effect at once and belong to idle periods.
`default_nettype none

module lamport_request_queue_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    mode,
    input  wire logic [lrq_pkg::STAMP_W-1:0]   stamp,
    input  wire logic [lrq_pkg::IDX_W-1:0]     proc_id,
    input  wire logic                          cfg_write,
    input  wire logic [lrq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lrq_pkg::CFG_W-1:0]     cfg_data,
    output logic                               done,
    output logic                               granted,
    output logic                               found,
    output logic [lrq_pkg::IDX_W-1:0]          position,
    output logic [lrq_pkg::CNT_W-1:0]          entry_total,
    output logic                               rejected
);
    import lrq_pkg::*;

    lrq_cmd_t cmd;

    lrq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    lrq_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .stamp       (stamp),
        .proc_id     (proc_id),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .granted     (granted),
        .found       (found),
        .position    (position),
        .entry_total (entry_total),
        .rejected    (rejected)
    );

endmodule

`default_nettype wire

### tb/lamport_request_queue_core_tb.sv
// Self-checking testbench for lamport_request_queue_core: directed and random transactions
// are checked against a behavioral copy of the queue kept in the testbench.
// Depends on lrq_pkg and the RTL of lamport_request_queue_core.
`default_nettype none

module lamport_request_queue_core_tb;

    import lrq_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int STALL_LIMIT    = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 160;
    localparam int PHASE_COUNT    = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [STAMP_W-1:0]   STAMP_MAX = {STAMP_W{1'b1}};

    typedef struct packed {
        logic               granted;
        logic               found;
        logic [IDX_W-1:0]   position;
        logic [CNT_W-1:0]   entry_total;
        logic               rejected;
    } queue_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           mode;
    logic [STAMP_W-1:0]   stamp;
    logic [IDX_W-1:0]     proc_id;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 done;
    logic                 granted;
    logic                 found;
    logic [IDX_W-1:0]     position;
    logic [CNT_W-1:0]     entry_total;
    logic                 rejected;

    // Behavioral copy of the block's state and registers.
    logic [STAMP_W-1:0] req_stamp [MAX_PROCS];
    logic [IDX_W-1:0]   req_id [MAX_PROCS];
    int unsigned        req_count;
    logic [STAMP_W-1:0] seen_stamp [MAX_PROCS];
    logic [CFG_W-1:0]   cfg_num_procs;
    logic [IDX_W-1:0]   cfg_own;
    logic [CFG_W-1:0]   cfg_slots;

    queue_result_t expected_results [$];

    logic [STAMP_W-1:0] lclock;
    bit                 sender_idles;
    int unsigned        n_errors;
    int unsigned        n_items;
    int unsigned        n_grants;
    int unsigned        n_denials;
    int unsigned        n_rejects;
    int unsigned        n_removed;
    int unsigned        n_settings;
    int unsigned        stall_cycles;

    lamport_request_queue_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .stamp       (stamp),
        .proc_id     (proc_id),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .granted     (granted),
        .found       (found),
        .position    (position),
        .entry_total (entry_total),
        .rejected    (rejected)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Applies one request to the copy of the queue and returns what the block must answer.
    function automatic queue_result_t apply_request(input mode_t op,
                                                    input logic [STAMP_W-1:0] ts,
                                                    input logic [IDX_W-1:0] pid);
        queue_result_t r;
        int unsigned   k;
        int unsigned   lim;
        int            pos;
        bit            ok;
        r = '0;
        case (op)
            MODE_INSERT: begin
                if (req_count >= MAX_PROCS) begin
                    r.rejected = 1'b1;
                end else begin
                    k = req_count;
                    while (k > 0 && (req_stamp[k-1] > ts ||
                                     (req_stamp[k-1] == ts && req_id[k-1] > pid))) begin
                        req_stamp[k] = req_stamp[k-1];
                        req_id[k]    = req_id[k-1];
                        k--;
                    end
                    req_stamp[k] = ts;
                    req_id[k]    = pid;
                    req_count++;
                end
            end
            MODE_REMOVE: begin
                pos = -1;
                for (int i = 0; i < req_count; i++)
                    if (pos < 0 && req_id[i] == pid)
                        pos = i;
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < req_count; i++) begin
                        req_stamp[i] = req_stamp[i+1];
                        req_id[i]    = req_id[i+1];
                    end
                    req_count--;
                    r.found = 1'b1;
                end
            end
            MODE_RECORD: begin
                seen_stamp[pid] = ts;
            end
            default: begin
                pos = -1;
                for (int i = 0; i < req_count; i++)
                    if (pos < 0 && req_id[i] == cfg_own)
                        pos = i;
                if (pos >= 0) begin
                    lim = (cfg_num_procs < MAX_PROCS) ? cfg_num_procs : MAX_PROCS;
                    ok  = (pos < cfg_slots);
                    for (int j = 0; j < lim; j++)
                        if (j != cfg_own && seen_stamp[j] <= ts)
                            ok = 1'b0;
                    r.found    = 1'b1;
                    r.position = pos[IDX_W-1:0];
                    r.granted  = ok;
                end
            end
        endcase
        r.entry_total = req_count[CNT_W-1:0];
        return r;
    endfunction

    // Offers one transaction, after a random gap if sender_idles is set, and waits until busy falls again.
    task automatic send_item(input mode_t op, input logic [STAMP_W-1:0] ts,
                             input logic [IDX_W-1:0] pid);
        int unsigned   gap;
        queue_result_t r;
        gap = sender_idles ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        mode    <= op;
        stamp   <= ts;
        proc_id <= pid;
        @(posedge clk);
        while (busy) @(posedge clk);
        r = apply_request(op, ts, pid);
        expected_results.push_back(r);
        n_items++;
        if (op == MODE_QUERY && r.found) begin
            if (r.granted) n_grants++;
            else           n_denials++;
        end
        if (r.rejected) n_rejects++;
        if (op == MODE_REMOVE && r.found) n_removed++;
        lclock = lclock + STAMP_W'($urandom_range(1, 8));
    endtask

    // Stops offering transactions and waits until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] np, input logic [CFG_W-1:0] oid,
                                 input logic [CFG_W-1:0] sl, input bit poke_spare);
        cfg_write <= 1'b1;
        cfg_index <= REG_NUM_PROCS;
        cfg_data  <= np;
        @(posedge clk);
        cfg_index <= REG_OWN_ID;
        cfg_data  <= oid;
        @(posedge clk);
        cfg_index <= REG_SLOTS;
        cfg_data  <= sl;
        @(posedge clk);
        // A write to the unused index must leave every register alone.
        if (poke_spare) begin
            cfg_index <= REG_SPARE;
            cfg_data  <= CFG_W'($urandom);
            @(posedge clk);
        end
        cfg_write     <= 1'b0;
        cfg_num_procs = np;
        cfg_own       = oid[IDX_W-1:0];
        cfg_slots     = sl;
        n_settings++;
    endtask

    function automatic logic [STAMP_W-1:0] pick_stamp();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return STAMP_MAX;
            2, 3:    return STAMP_W'($urandom);
            4, 5:    return lclock + STAMP_W'($urandom_range(0, 3));
            default: return lclock - STAMP_W'(200) + STAMP_W'($urandom_range(0, 400));
        endcase
    endfunction

    task automatic test_edge_items();
        send_item(MODE_QUERY, '0, 4'd0);
        send_item(MODE_REMOVE, STAMP_MAX, 4'd5);
        send_item(MODE_RECORD, STAMP_MAX, 4'd15);
        // A later record with a smaller stamp still overwrites.
        send_item(MODE_RECORD, 31'h1234_5678, 4'd15);
        send_item(MODE_RECORD, '0, 4'd0);
        send_item(MODE_INSERT, '0, 4'd0);
        send_item(MODE_QUERY, '0, 4'd9);
        send_item(MODE_REMOVE, '0, 4'd0);
    endtask

    task automatic test_full_queue();
        logic [STAMP_W-1:0] ts;
        // Descending ids on equal stamps force the tie-break to shift entries.
        for (int i = 0; i < MAX_PROCS; i++) begin
            ts = (i == 0) ? STAMP_MAX : (i == 1) ? '0 : STAMP_W'(100 + i % 3);
            send_item(MODE_INSERT, ts, IDX_W'(MAX_PROCS - 1 - i));
        end
        send_item(MODE_INSERT, STAMP_W'(50), 4'd6);
    endtask

    task automatic test_settings_sweep();
        drain_results();
        load_settings(5'd1, 5'd0, 5'd16, 1'b0);
        send_item(MODE_QUERY, STAMP_MAX, 4'd3);
        drain_results();
        load_settings(5'd0, 5'd15, 5'd0, 1'b0);
        send_item(MODE_QUERY, '0, 4'd12);
        drain_results();
        load_settings(5'd31, 5'd31, 5'd31, 1'b1);
        send_item(MODE_QUERY, STAMP_MAX, 4'd0);
        drain_results();
        load_settings(5'd16, 5'd0, 5'd1, 1'b0);
        send_item(MODE_QUERY, '0, 4'd15);
    endtask

    // This node's access round: others' stamps (one may be stale), own request, query, maybe a release.
    task automatic run_access_round(inout int unsigned sent);
        logic [STAMP_W-1:0] base;
        logic [STAMP_W-1:0] ts;
        int unsigned        stale_pid;
        base      = lclock;
        stale_pid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_PROCS - 1) : MAX_PROCS;
        for (int j = 0; j < MAX_PROCS; j++) begin
            if (j != cfg_own) begin
                if (j == stale_pid)
                    ts = base - STAMP_W'($urandom_range(0, 20));
                else
                    ts = base + STAMP_W'($urandom_range(1, 500));
                send_item(MODE_RECORD, ts, IDX_W'(j));
                sent++;
            end
        end
        send_item(MODE_INSERT, base, cfg_own);
        send_item(MODE_QUERY, base, IDX_W'($urandom));
        sent += 2;
        if ($urandom_range(0, 3) != 0) begin
            send_item(MODE_REMOVE, STAMP_W'($urandom), cfg_own);
            sent++;
        end
    endtask

    task automatic test_random_traffic();
        int unsigned        sent;
        int unsigned        pick;
        mode_t              op;
        logic [CFG_W-1:0]   np;
        logic [CFG_W-1:0]   oid;
        logic [CFG_W-1:0]   sl;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_results();
            case (ph)
                0:       begin np = 5'd16; oid = 5'd0;  sl = 5'd1;  end
                1:       begin np = 5'd1;  oid = 5'd15; sl = 5'd16; end
                2:       begin np = 5'd31; oid = 5'd7;  sl = 5'd0;  end
                3:       begin np = 5'd0;  oid = 5'd3;  sl = 5'd31; end
                default: begin
                    np  = CFG_W'($urandom_range(0, 31));
                    oid = CFG_W'($urandom_range(0, 31));
                    sl  = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                                      : CFG_W'($urandom_range(1, 4));
                end
            endcase
            load_settings(np, oid, sl, ph == 5);
            sender_idles = (ph % 3 != 1);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 30) begin
                    run_access_round(sent);
                end else begin
                    pick = $urandom_range(0, 99);
                    op   = (pick < 30) ? MODE_INSERT :
                           (pick < 65) ? MODE_REMOVE :
                           (pick < 80) ? MODE_RECORD : MODE_QUERY;
                    send_item(op, pick_stamp(), IDX_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk) begin : check_results
        queue_result_t want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("result with no transaction outstanding");
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, granted);
                    n_errors++;
                end
                if (found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    n_errors++;
                end
                if (position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    n_errors++;
                end
                if (entry_total !== want.entry_total) begin
                    $error("entry_total: expected %0d, got %0d", want.entry_total, entry_total);
                    n_errors++;
                end
                if (rejected !== want.rejected) begin
                    $error("rejected: expected %0d, got %0d", want.rejected, rejected);
                    n_errors++;
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither a transaction nor a result moves.
    always @(posedge clk) begin
        if ((start && !busy) || done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        rst_n         = 1'b0;
        start         = 1'b0;
        mode          = MODE_INSERT;
        stamp         = '0;
        proc_id       = '0;
        cfg_write     = 1'b0;
        cfg_index     = REG_NUM_PROCS;
        cfg_data      = '0;
        stall_cycles  = 0;
        n_errors      = 0;
        n_items       = 0;
        n_grants      = 0;
        n_denials     = 0;
        n_rejects     = 0;
        n_removed     = 0;
        n_settings    = 0;
        req_count     = 0;
        cfg_num_procs = 5'd16;
        cfg_own       = '0;
        cfg_slots     = 5'd1;
        sender_idles  = 1'b1;
        lclock        = STAMP_W'($urandom);
        for (int i = 0; i < MAX_PROCS; i++) begin
            req_stamp[i]  = '0;
            req_id[i]     = '0;
            seen_stamp[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_edge_items();
        test_full_queue();
        test_settings_sweep();
        test_random_traffic();
        drain_results();

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            n_errors++;
        end
        $display("Ran %0d transactions over %0d register settings.", n_items, n_settings);
        $display("Access granted %0d times, denied %0d times; %0d inserts refused, %0d removals.",
                 n_grants, n_denials, n_rejects, n_removed);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
